// ===== hw/rtl/caf_pkg.sv =====
// ----------------------------------------------------------------------------
// caf_pkg
// Shared types and codes for the flag-producing cpu alu pipeline.
// ----------------------------------------------------------------------------
package caf_pkg;

  // alu command codes, code 15 is unused and behaves as a no-op
  typedef enum logic [3:0] {
    CMD_ADD    = 4'd0,
    CMD_ADC    = 4'd1,
    CMD_SUB    = 4'd2,
    CMD_SBC    = 4'd3,
    CMD_CP     = 4'd4,
    CMD_AND    = 4'd5,
    CMD_OR     = 4'd6,
    CMD_XOR    = 4'd7,
    CMD_INC8   = 4'd8,
    CMD_DEC8   = 4'd9,
    CMD_INC16  = 4'd10,
    CMD_DEC16  = 4'd11,
    CMD_ADD16  = 4'd12,
    CMD_ADDSPE = 4'd13,
    CMD_CB     = 4'd14
  } cmd_e;

  // cb opcode groups, opcode bits 7:6
  typedef enum logic [1:0] {
    CB_GRP_SHIFT = 2'd0,
    CB_GRP_BIT   = 2'd1,
    CB_GRP_RES   = 2'd2,
    CB_GRP_SET   = 2'd3
  } cb_grp_e;

  // shift/rotate selection, opcode bits 5:3 in the shift group
  typedef enum logic [2:0] {
    CB_RLC  = 3'd0,
    CB_RRC  = 3'd1,
    CB_RL   = 3'd2,
    CB_RR   = 3'd3,
    CB_SLA  = 3'd4,
    CB_SRA  = 3'd5,
    CB_SWAP = 3'd6,
    CB_SRL  = 3'd7
  } cb_shift_e;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // cb unit result
  typedef struct packed {
    logic [7:0] res;
    logic [3:0] flags;
    logic       wr;
  } cb_res_t;

  // decode stage register contents
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] x;
    logic [15:0] y;
    logic        cin;
    logic [7:0]  a8;
    logic [7:0]  b8;
    logic [3:0]  fin;
  } s1_t;

  // execute stage register contents
  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  fin;
    logic [15:0] sum;
    logic        c4;
    logic        c8;
    logic        c12;
    logic        c16;
    logic [7:0]  logic8;
    cb_res_t     cb;
  } s2_t;

endpackage

// ===== hw/rtl/cpu_alu_with_flags_unit.sv =====
// stages: an accepted request moves through the decode and execute stage
//   registers into the flag stage, whose registers drive the outputs
// throughput: one request per cycle; each stage holds under backpressure on
//   its own, so bubbles are squeezed out and nothing is lost or repeated
// reset: rst_ni low clears all stage valid bits at once; data regs keep junk
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_unit
// Three-stage pipelined 8/16-bit cpu alu producing z/n/h/c flags, including
// the prefixed rotate, shift, swap and bit operations.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  cmd_i,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  input  logic [3:0]  flags_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_o,
  output logic [3:0]  flags_out_o,
  output logic        write_result_o
);

  // --------------------------------------------------------------------------
  // pipeline control: each stage may load when it is empty or its
  // successor takes its contents this cycle
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3       = !s3_valid_q || out_ready_i;
  assign rdy2       = !s2_valid_q || rdy3;
  assign rdy1       = !s1_valid_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (rdy1) s1_valid_q <= in_valid_i;
      if (rdy2) s2_valid_q <= s1_valid_q;
      if (rdy3) s3_valid_q <= s2_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: decode into one shared adder setup
  // subtraction runs as a + ~b + !k, so carries out become inverted borrows
  // --------------------------------------------------------------------------
  caf_pkg::s1_t s1_d, s1_q;

  always_comb begin
    s1_d     = '0;
    s1_d.cmd = caf_pkg::cmd_e'(cmd_i);
    s1_d.a8  = operand_a_i[7:0];
    s1_d.b8  = operand_b_i[7:0];
    s1_d.fin = flags_in_i;
    case (caf_pkg::cmd_e'(cmd_i))
      caf_pkg::CMD_ADD: begin
        s1_d.x   = {8'h00, operand_a_i[7:0]};
        s1_d.y   = {8'h00, operand_b_i[7:0]};
        s1_d.cin = 1'b0;
      end
      caf_pkg::CMD_ADC: begin
        s1_d.x   = {8'h00, operand_a_i[7:0]};
        s1_d.y   = {8'h00, operand_b_i[7:0]};
        s1_d.cin = flags_in_i[caf_pkg::FLAG_C];
      end
      caf_pkg::CMD_SUB, caf_pkg::CMD_CP: begin
        s1_d.x   = {8'h00, operand_a_i[7:0]};
        s1_d.y   = {8'h00, ~operand_b_i[7:0]};
        s1_d.cin = 1'b1;
      end
      caf_pkg::CMD_SBC: begin
        s1_d.x   = {8'h00, operand_a_i[7:0]};
        s1_d.y   = {8'h00, ~operand_b_i[7:0]};
        s1_d.cin = !flags_in_i[caf_pkg::FLAG_C];
      end
      caf_pkg::CMD_INC8: begin
        s1_d.x   = {8'h00, operand_a_i[7:0]};
        s1_d.y   = 16'h0000;
        s1_d.cin = 1'b1;
      end
      caf_pkg::CMD_DEC8: begin
        // a + 0xff: nibble carry is missing only when the low nibble is zero
        s1_d.x   = {8'h00, operand_a_i[7:0]};
        s1_d.y   = 16'h00FF;
        s1_d.cin = 1'b0;
      end
      caf_pkg::CMD_INC16: begin
        s1_d.x   = operand_a_i;
        s1_d.y   = 16'h0000;
        s1_d.cin = 1'b1;
      end
      caf_pkg::CMD_DEC16: begin
        s1_d.x   = operand_a_i;
        s1_d.y   = 16'hFFFF;
        s1_d.cin = 1'b0;
      end
      caf_pkg::CMD_ADD16: begin
        s1_d.x   = operand_a_i;
        s1_d.y   = operand_b_i;
        s1_d.cin = 1'b0;
      end
      caf_pkg::CMD_ADDSPE: begin
        // sign-extended offset; its low byte equals the raw byte for h and c
        s1_d.x   = operand_a_i;
        s1_d.y   = {{8{operand_b_i[7]}}, operand_b_i[7:0]};
        s1_d.cin = 1'b0;
      end
      default: begin
        s1_d.x   = 16'h0000;
        s1_d.y   = 16'h0000;
        s1_d.cin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) s1_q <= s1_d;
  end

  // --------------------------------------------------------------------------
  // stage 2: execute; one 16-bit add with carries tapped at bits 4/8/12/16,
  // the 8-bit logic ops and the prefixed unit side by side
  // --------------------------------------------------------------------------
  caf_pkg::s2_t     s2_d, s2_q;
  caf_pkg::cb_res_t cb_res;
  logic [16:0]      sum17;

  assign sum17 = {1'b0, s1_q.x} + {1'b0, s1_q.y} + {16'h0000, s1_q.cin};

  caf_cb_unit u_cb (
    .val_i   (s1_q.a8),
    .op_i    (s1_q.b8),
    .carry_i (s1_q.fin[caf_pkg::FLAG_C]),
    .flags_i (s1_q.fin),
    .res_o   (cb_res)
  );

  always_comb begin
    s2_d     = '0;
    s2_d.cmd = s1_q.cmd;
    s2_d.fin = s1_q.fin;
    s2_d.sum = sum17[15:0];
    // carry into bit i recovered from the sum bit and the operand bits
    s2_d.c4  = sum17[4] ^ s1_q.x[4] ^ s1_q.y[4];
    s2_d.c8  = sum17[8] ^ s1_q.x[8] ^ s1_q.y[8];
    s2_d.c12 = sum17[12] ^ s1_q.x[12] ^ s1_q.y[12];
    s2_d.c16 = sum17[16];
    s2_d.cb  = cb_res;
    case (s1_q.cmd)
      caf_pkg::CMD_AND: s2_d.logic8 = s1_q.a8 & s1_q.b8;
      caf_pkg::CMD_OR:  s2_d.logic8 = s1_q.a8 | s1_q.b8;
      default:          s2_d.logic8 = s1_q.a8 ^ s1_q.b8;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && rdy2) s2_q <= s2_d;
  end

  // --------------------------------------------------------------------------
  // stage 3: result select, zero detect and flag assembly into the
  // output registers
  // --------------------------------------------------------------------------
  logic [15:0] res_d, res_q;
  logic [3:0]  flags_d, flags_q;
  logic        wr_d, wr_q;
  logic        z8;

  // zero test of the low byte of whichever 8-bit value applies
  always_comb begin
    case (s2_q.cmd)
      caf_pkg::CMD_AND, caf_pkg::CMD_OR, caf_pkg::CMD_XOR: z8 = ~|s2_q.logic8;
      default:                                             z8 = ~|s2_q.sum[7:0];
    endcase
  end

  always_comb begin
    res_d   = {8'h00, s2_q.sum[7:0]};
    flags_d = s2_q.fin;
    wr_d    = 1'b1;
    case (s2_q.cmd)
      caf_pkg::CMD_ADD, caf_pkg::CMD_ADC: begin
        flags_d = {z8, 1'b0, s2_q.c4, s2_q.c8};
      end
      caf_pkg::CMD_SUB, caf_pkg::CMD_SBC: begin
        flags_d = {z8, 1'b1, !s2_q.c4, !s2_q.c8};
      end
      caf_pkg::CMD_CP: begin
        flags_d = {z8, 1'b1, !s2_q.c4, !s2_q.c8};
        wr_d    = 1'b0;
      end
      caf_pkg::CMD_AND: begin
        res_d   = {8'h00, s2_q.logic8};
        flags_d = {z8, 1'b0, 1'b1, 1'b0};
      end
      caf_pkg::CMD_OR, caf_pkg::CMD_XOR: begin
        res_d   = {8'h00, s2_q.logic8};
        flags_d = {z8, 1'b0, 1'b0, 1'b0};
      end
      caf_pkg::CMD_INC8: begin
        flags_d = {z8, 1'b0, s2_q.c4, s2_q.fin[caf_pkg::FLAG_C]};
      end
      caf_pkg::CMD_DEC8: begin
        flags_d = {z8, 1'b1, !s2_q.c4, s2_q.fin[caf_pkg::FLAG_C]};
      end
      caf_pkg::CMD_INC16, caf_pkg::CMD_DEC16: begin
        res_d = s2_q.sum;
      end
      caf_pkg::CMD_ADD16: begin
        // z kept, h from bit 11, c from bit 15
        res_d   = s2_q.sum;
        flags_d = {s2_q.fin[caf_pkg::FLAG_Z], 1'b0, s2_q.c12, s2_q.c16};
      end
      caf_pkg::CMD_ADDSPE: begin
        // h and c come from the unsigned low-byte add
        res_d   = s2_q.sum;
        flags_d = {1'b0, 1'b0, s2_q.c4, s2_q.c8};
      end
      caf_pkg::CMD_CB: begin
        res_d   = {8'h00, s2_q.cb.res};
        flags_d = s2_q.cb.flags;
        wr_d    = s2_q.cb.wr;
      end
      default: begin
        // unused code: no operation
        res_d   = 16'h0000;
        flags_d = s2_q.fin;
        wr_d    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && rdy3) begin
      res_q   <= res_d;
      flags_q <= flags_d;
      wr_q    <= wr_d;
    end
  end

  assign out_valid_o    = s3_valid_q;
  assign result_o       = res_q;
  assign flags_out_o    = flags_q;
  assign write_result_o = wr_q;

`ifndef SYNTHESIS
  // compare never writes back
  a_cp_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && rdy3 && s2_q.cmd == caf_pkg::CMD_CP |=> !write_result_o)
    else $error("compare result marked for write-back");

  // 8-bit commands leave the high byte clear
  a_byte_high_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && rdy3 && (s2_q.cmd <= caf_pkg::CMD_DEC8 || s2_q.cmd == caf_pkg::CMD_CB)
    |=> result_o[15:8] == 8'h00)
    else $error("8-bit result with nonzero high byte");

  // 16-bit add always clears n
  a_add16_n_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && rdy3 && s2_q.cmd == caf_pkg::CMD_ADD16 |=> !flags_out_o[caf_pkg::FLAG_N])
    else $error("16-bit add left n set");

  // an output only appears from a filled execute stage
  a_out_from_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s3_valid_q) |-> $past(s2_valid_q))
    else $error("output valid without a request in the execute stage");

  // input side only stalls when the whole pipe is full and blocked
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s2_valid_q && s3_valid_q && !out_ready_i)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

// ===== hw/rtl/caf_cb_unit.sv =====
// ----------------------------------------------------------------------------
// caf_cb_unit
// Prefixed bit operations: rotates, shifts, swap, bit test, reset and set.
// ----------------------------------------------------------------------------
module caf_cb_unit (
  input  logic [7:0]       val_i,
  input  logic [7:0]       op_i,
  input  logic             carry_i,
  input  logic [3:0]       flags_i,
  output caf_pkg::cb_res_t res_o
);

  logic [2:0] sel;
  logic [7:0] mask;
  logic [7:0] r;
  logic       c;

  assign sel  = op_i[5:3];
  assign mask = 8'd1 << sel;

  always_comb begin
    r = val_i;
    c = 1'b0;
    case (caf_pkg::cb_shift_e'(sel))
      caf_pkg::CB_RLC:  begin c = val_i[7]; r = {val_i[6:0], val_i[7]}; end
      caf_pkg::CB_RRC:  begin c = val_i[0]; r = {val_i[0], val_i[7:1]}; end
      caf_pkg::CB_RL:   begin c = val_i[7]; r = {val_i[6:0], carry_i}; end
      caf_pkg::CB_RR:   begin c = val_i[0]; r = {carry_i, val_i[7:1]}; end
      caf_pkg::CB_SLA:  begin c = val_i[7]; r = {val_i[6:0], 1'b0}; end
      caf_pkg::CB_SRA:  begin c = val_i[0]; r = {val_i[7], val_i[7:1]}; end
      caf_pkg::CB_SWAP: begin c = 1'b0;     r = {val_i[3:0], val_i[7:4]}; end
      caf_pkg::CB_SRL:  begin c = val_i[0]; r = {1'b0, val_i[7:1]}; end
      default:          begin c = 1'b0;     r = val_i; end
    endcase
  end

  always_comb begin
    res_o = '0;
    case (caf_pkg::cb_grp_e'(op_i[7:6]))
      caf_pkg::CB_GRP_BIT: begin
        // z set when the tested bit is clear, c kept
        res_o.res   = val_i;
        res_o.flags = {~|(val_i & mask), 1'b0, 1'b1, flags_i[caf_pkg::FLAG_C]};
        res_o.wr    = 1'b0;
      end
      caf_pkg::CB_GRP_RES: begin
        res_o.res   = val_i & ~mask;
        res_o.flags = flags_i;
        res_o.wr    = 1'b1;
      end
      caf_pkg::CB_GRP_SET: begin
        res_o.res   = val_i | mask;
        res_o.flags = flags_i;
        res_o.wr    = 1'b1;
      end
      default: begin
        res_o.res   = r;
        res_o.flags = {~|r, 1'b0, 1'b0, c};
        res_o.wr    = 1'b1;
      end
    endcase
  end

endmodule

// ===== sim/cpu_alu_with_flags_unit_test.sv =====
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_unit_test
// Self-checking bench for the pipelined alu: a typed directed table, then
// random requests, each compared field by field against a local flag model.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags_unit_test;
  import caf_pkg::*;

  // command code 15 has no package name, it is a no-op in the block
  localparam logic [3:0] CMD_NOP = 4'd15;

  // flag masks in the flags_in / flags_out layout
  localparam logic [3:0] FL_Z = 4'b1 << FLAG_Z;
  localparam logic [3:0] FL_N = 4'b1 << FLAG_N;
  localparam logic [3:0] FL_H = 4'b1 << FLAG_H;
  localparam logic [3:0] FL_C = 4'b1 << FLAG_C;

  localparam int unsigned RANDOM_REQS   = 1924;
  localparam int unsigned PAUSE_AT_REQ  = 1000; // sender drains the pipe here
  localparam int unsigned HOLD_AT_RESP  = 400;  // receiver stops taking results
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned DRAIN_CYCLES  = 8;    // three stages plus margin

  typedef struct packed {
    logic [3:0]  cmd;
    logic [15:0] a;
    logic [15:0] b;
    logic [3:0]  flags;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags;
    logic        wr;
  } alu_res_t;

  typedef struct packed {
    alu_req_t req;
    logic     typed;  // expected value written into the row by hand
    alu_res_t res;
  } dir_row_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [3:0]  cmd_i          = '0;
  logic [15:0] operand_a_i    = '0;
  logic [15:0] operand_b_i    = '0;
  logic [3:0]  flags_in_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [15:0] result_o;
  logic [3:0]  flags_out_o;
  logic        write_result_o;

  // results still owed by the block, oldest first
  alu_res_t    pending_results[$];
  dir_row_t    dir_rows[$];
  alu_res_t    head_res;
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned rx_cycle       = 0;
  int unsigned rx_hold_left   = 0;
  bit          rx_hold_done   = 1'b0;

  cpu_alu_with_flags_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .flags_in_i     (flags_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_o       (result_o),
    .flags_out_o    (flags_out_o),
    .write_result_o (write_result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [3:0] pack_flags(logic z, logic n, logic h, logic c);
    logic [3:0] f;
    f = '0;
    f[FLAG_Z] = z;
    f[FLAG_N] = n;
    f[FLAG_H] = h;
    f[FLAG_C] = c;
    return f;
  endfunction

  // flag model of one request; 8-bit commands look only at the low bytes
  function automatic alu_res_t predict_alu(alu_req_t rq);
    logic [7:0]  a8;
    logic [7:0]  b8;
    logic [7:0]  r8;
    logic [7:0]  mask;
    logic [8:0]  sum9;
    logic [4:0]  lo5;
    logic [12:0] lo13;
    logic [16:0] sum17;
    logic        cin;
    logic        k;
    logic        cy;
    alu_res_t    o;
    a8       = rq.a[7:0];
    b8       = rq.b[7:0];
    cin      = rq.flags[FLAG_C];
    o.result = '0;
    o.flags  = rq.flags;
    o.wr     = 1'b1;
    case (rq.cmd)
      CMD_ADD, CMD_ADC: begin
        k        = (rq.cmd == CMD_ADC) ? cin : 1'b0;
        sum9     = 9'(a8) + 9'(b8) + 9'(k);
        lo5      = 5'(a8[3:0]) + 5'(b8[3:0]) + 5'(k);
        o.result = {8'h00, sum9[7:0]};
        o.flags  = pack_flags(sum9[7:0] == 8'h00, 1'b0, lo5[4], sum9[8]);
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        k        = (rq.cmd == CMD_SBC) ? cin : 1'b0;
        r8       = a8 - b8 - 8'(k);
        o.result = {8'h00, r8};
        o.flags  = pack_flags(r8 == 8'h00, 1'b1,
                              5'(a8[3:0]) < 5'(b8[3:0]) + 5'(k),
                              9'(a8) < 9'(b8) + 9'(k));
        // compare keeps the difference but does not write it back
        if (rq.cmd == CMD_CP) o.wr = 1'b0;
      end
      CMD_AND: begin
        r8       = a8 & b8;
        o.result = {8'h00, r8};
        o.flags  = pack_flags(r8 == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      CMD_OR: begin
        r8       = a8 | b8;
        o.result = {8'h00, r8};
        o.flags  = pack_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      CMD_XOR: begin
        r8       = a8 ^ b8;
        o.result = {8'h00, r8};
        o.flags  = pack_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      CMD_INC8: begin
        r8       = a8 + 8'd1;
        o.result = {8'h00, r8};
        o.flags  = pack_flags(r8 == 8'h00, 1'b0, a8[3:0] == 4'hF, cin);
      end
      CMD_DEC8: begin
        r8       = a8 - 8'd1;
        o.result = {8'h00, r8};
        o.flags  = pack_flags(r8 == 8'h00, 1'b1, a8[3:0] == 4'h0, cin);
      end
      // 16-bit inc/dec wrap and leave flags as they came in
      CMD_INC16: o.result = rq.a + 16'd1;
      CMD_DEC16: o.result = rq.a - 16'd1;
      CMD_ADD16: begin
        sum17    = 17'(rq.a) + 17'(rq.b);
        lo13     = 13'(rq.a[11:0]) + 13'(rq.b[11:0]);
        o.result = sum17[15:0];
        o.flags  = pack_flags(rq.flags[FLAG_Z], 1'b0, lo13[12], sum17[16]);
      end
      CMD_ADDSPE: begin
        // signed offset for the sum, unsigned low byte for h and c
        o.result = rq.a + {{8{b8[7]}}, b8};
        lo5      = 5'(rq.a[3:0]) + 5'(b8[3:0]);
        sum9     = 9'(rq.a[7:0]) + 9'(b8);
        o.flags  = pack_flags(1'b0, 1'b0, lo5[4], sum9[8]);
      end
      CMD_CB: begin
        mask = 8'b1 << b8[5:3];
        case (cb_grp_e'(b8[7:6]))
          CB_GRP_BIT: begin
            o.result = {8'h00, a8};
            o.flags  = pack_flags((a8 & mask) == 8'h00, 1'b0, 1'b1, cin);
            o.wr     = 1'b0;
          end
          CB_GRP_RES: o.result = {8'h00, a8 & ~mask};
          CB_GRP_SET: o.result = {8'h00, a8 | mask};
          default: begin
            case (cb_shift_e'(b8[5:3]))
              CB_RLC:  begin cy = a8[7]; r8 = {a8[6:0], a8[7]}; end
              CB_RRC:  begin cy = a8[0]; r8 = {a8[0], a8[7:1]}; end
              CB_RL:   begin cy = a8[7]; r8 = {a8[6:0], cin}; end
              CB_RR:   begin cy = a8[0]; r8 = {cin, a8[7:1]}; end
              CB_SLA:  begin cy = a8[7]; r8 = {a8[6:0], 1'b0}; end
              CB_SRA:  begin cy = a8[0]; r8 = {a8[7], a8[7:1]}; end
              CB_SWAP: begin cy = 1'b0;  r8 = {a8[3:0], a8[7:4]}; end
              default: begin cy = a8[0]; r8 = {1'b0, a8[7:1]}; end
            endcase
            o.result = {8'h00, r8};
            o.flags  = pack_flags(r8 == 8'h00, 1'b0, 1'b0, cy);
          end
        endcase
      end
      // unused code: nothing computed, nothing written, flags pass through
      default: begin
        o.result = '0;
        o.wr     = 1'b0;
      end
    endcase
    return o;
  endfunction

  // operand source weighted toward carry and borrow boundaries
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return {8'($urandom), 8'hFF};
      3:       return {8'($urandom), 4'($urandom), 4'hF};
      4:       return {4'hF, 12'hFFF - 12'($urandom_range(0, 3))};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_row(logic [3:0] c, logic [15:0] a, logic [15:0] b, logic [3:0] f,
                         logic typed, logic [15:0] r, logic [3:0] fo, logic wr);
    dir_row_t row;
    row.req   = '{cmd: c, a: a, b: b, flags: f};
    row.typed = typed;
    row.res   = '{result: r, flags: fo, wr: wr};
    dir_rows.push_back(row);
  endtask

  // present one request and hold it until the block takes it; the caller
  // decides whether valid stays up for the next one
  task automatic offer_request(alu_req_t rq, alu_res_t owed);
    in_valid_i  <= 1'b1;
    cmd_i       <= rq.cmd;
    operand_a_i <= rq.a;
    operand_b_i <= rq.b;
    flags_in_i  <= rq.flags;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(owed);
  endtask

  // result checking plus the receiver's own stall pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result: result=%h flags_out=%h write_result=%b",
                 result_o, flags_out_o, write_result_o);
          mismatch_count++;
        end else begin
          head_res = pending_results.pop_front();
          if (result_o !== head_res.result) begin
            $error("result: expected %h, got %h", head_res.result, result_o);
            mismatch_count++;
          end
          if (flags_out_o !== head_res.flags) begin
            $error("flags_out: expected %b, got %b", head_res.flags, flags_out_o);
            mismatch_count++;
          end
          if (write_result_o !== head_res.wr) begin
            $error("write_result: expected %b, got %b", head_res.wr, write_result_o);
            mismatch_count++;
          end
        end
      end

      rx_cycle++;
      // one long hold-off so the stages back up into in_ready_o
      if (!rx_hold_done && results_seen >= HOLD_AT_RESP) begin
        rx_hold_left = HOLD_CYCLES;
        rx_hold_done = 1'b1;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        // rotate through always-ready, coin flip, 3-of-4 and mostly-stalled
        case ((rx_cycle / 128) % 4)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= (rx_cycle % 4) != 3;
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    alu_req_t    rq;
    alu_res_t    owed;
    int unsigned burst_left;
    int unsigned gap;

    // directed table: boundaries, every command and the odd flag rules
    // carry out of both nibble and byte
    add_row(CMD_ADD, 16'h00FF, 16'h0001, 4'h0, 1, 16'h0000, FL_Z | FL_H | FL_C, 1);
    // high bytes are ignored by 8-bit commands
    add_row(CMD_ADD, 16'hAB12, 16'hCD34, 4'hF, 0, '0, '0, 0);
    add_row(CMD_ADC, 16'h000F, 16'h0000, FL_C, 1, 16'h0010, FL_H, 1);
    add_row(CMD_SUB, 16'h0000, 16'h0001, 4'h0, 1, 16'h00FF, FL_N | FL_H | FL_C, 1);
    add_row(CMD_SBC, 16'h0010, 16'h000F, FL_C, 1, 16'h0000, FL_Z | FL_N | FL_H, 1);
    // compare keeps the difference but does not write it
    add_row(CMD_CP, 16'h0042, 16'h0042, 4'h0, 1, 16'h0000, FL_Z | FL_N, 0);
    add_row(CMD_AND, 16'h00F0, 16'h000F, 4'h0, 1, 16'h0000, FL_Z | FL_H, 1);
    add_row(CMD_OR, 16'hFF00, 16'hFF00, 4'hF, 1, 16'h0000, FL_Z, 1);
    add_row(CMD_XOR, 16'h00FF, 16'h00FF, 4'h7, 1, 16'h0000, FL_Z, 1);
    // 8-bit inc/dec: zero from the byte result, carry kept
    add_row(CMD_INC8, 16'h00FF, 16'h0000, FL_C, 1, 16'h0000, FL_Z | FL_H | FL_C, 1);
    add_row(CMD_DEC8, 16'h0001, 16'h0000, 4'h0, 1, 16'h0000, FL_Z | FL_N, 1);
    add_row(CMD_DEC8, 16'hFF00, 16'h0000, 4'hF, 1, 16'h00FF, FL_N | FL_H | FL_C, 1);
    // 16-bit inc/dec wrap, flags untouched
    add_row(CMD_INC16, 16'hFFFF, 16'h0000, 4'hA, 1, 16'h0000, 4'hA, 1);
    add_row(CMD_DEC16, 16'h0000, 16'hFFFF, 4'h5, 1, 16'hFFFF, 4'h5, 1);
    // 16-bit add: half carry out of bit 11, zero kept
    add_row(CMD_ADD16, 16'h0FFF, 16'h0001, FL_Z, 1, 16'h1000, FL_Z | FL_H, 1);
    add_row(CMD_ADD16, 16'hFFFF, 16'hFFFF, 4'h0, 1, 16'hFFFE, FL_H | FL_C, 1);
    // sp plus offset: zero flag forced low even for a zero sum
    add_row(CMD_ADDSPE, 16'hFFF8, 16'hFF08, FL_Z | FL_N, 1, 16'h0000, FL_H | FL_C, 1);
    add_row(CMD_ADDSPE, 16'h0000, 16'h0080, 4'hF, 1, 16'hFF80, 4'h0, 1);
    // prefixed group: rotates, shifts, swap, bit, res, set
    add_row(CMD_CB, 16'hFF80, {8'hFF, CB_GRP_SHIFT, CB_RLC, 3'd0}, 4'h0,
            1, 16'h0001, FL_C, 1);
    add_row(CMD_CB, 16'h0001, {8'h00, CB_GRP_SHIFT, CB_RR, 3'd0}, FL_C, 0, '0, '0, 0);
    add_row(CMD_CB, 16'h00A5, {8'hAB, CB_GRP_SHIFT, CB_SWAP, 3'd0}, FL_C,
            1, 16'h005A, 4'h0, 1);
    add_row(CMD_CB, 16'h0081, {8'h00, CB_GRP_SHIFT, CB_SRA, 3'd0}, 4'h0, 0, '0, '0, 0);
    // bit test: operand passes through, no write, carry kept
    add_row(CMD_CB, 16'h007F, {8'h00, CB_GRP_BIT, 3'd7, 3'd0}, FL_N | FL_C,
            1, 16'h007F, FL_Z | FL_H | FL_C, 0);
    add_row(CMD_CB, 16'h00FF, {8'h00, CB_GRP_RES, 3'd0, 3'd0}, 4'h6, 1, 16'h00FE, 4'h6, 1);
    add_row(CMD_CB, 16'hFF00, {8'h00, CB_GRP_SET, 3'd7, 3'd0}, 4'h9, 1, 16'h0080, 4'h9, 1);
    // unused command code
    add_row(CMD_NOP, 16'hFFFF, 16'hFFFF, 4'hC, 1, 16'h0000, 4'hC, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      owed = dir_rows[i].typed ? dir_rows[i].res : predict_alu(dir_rows[i].req);
      offer_request(dir_rows[i].req, owed);
    end

    burst_left = 0;
    for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
      if (n == PAUSE_AT_REQ) begin
        // let the whole pipe drain before carrying on
        in_valid_i <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        // a stretch with no gaps at all, the rest gets short random gaps
        gap = (n >= 600 && n < 900) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      rq.cmd   = 4'($urandom_range(0, 15));
      rq.a     = pick_operand();
      rq.b     = pick_operand();
      rq.flags = 4'($urandom);
      // prefixed ops: half the time, draw the opcode byte uniformly over all groups
      if (rq.cmd == CMD_CB && $urandom_range(0, 1)) rq.b[7:0] = 8'($urandom);
      offer_request(rq, predict_alu(rq));
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
